/* design/hrst_pkg.sv */
// Package for the heap region state tracker.
// Holds region state codes, owner codes, event codes and the sequencer state type.
// No dependencies.
package hrst_pkg;

	typedef enum logic [3:0] {
		RS_EMPTY_UNC = 4'd0,
		RS_EMPTY_COM = 4'd1,
		RS_REGULAR   = 4'd2,
		RS_HUM_START = 4'd3,
		RS_HUM_CONT  = 4'd4,
		RS_PIN_HUM   = 4'd5,
		RS_CSET      = 4'd6,
		RS_PINNED    = 4'd7,
		RS_PIN_CSET  = 4'd8,
		RS_TRASH     = 4'd9
	} rstate_t;

	localparam logic [1:0] OWN_FREE  = 2'd0;
	localparam logic [1:0] OWN_YOUNG = 2'd1;
	localparam logic [1:0] OWN_OLD   = 2'd2;

	localparam logic [4:0] EV_REGALLOC      = 5'd0;
	localparam logic [4:0] EV_YOUNGIFREE    = 5'd1;
	localparam logic [4:0] EV_REGBYPASS     = 5'd2;
	localparam logic [4:0] EV_HUMSTART      = 5'd3;
	localparam logic [4:0] EV_HUMSTART_BYP  = 5'd4;
	localparam logic [4:0] EV_HUMCONT       = 5'd5;
	localparam logic [4:0] EV_HUMCONT_BYP   = 5'd6;
	localparam logic [4:0] EV_PIN           = 5'd7;
	localparam logic [4:0] EV_UNPIN         = 5'd8;
	localparam logic [4:0] EV_CSET          = 5'd9;
	localparam logic [4:0] EV_TRASH         = 5'd10;
	localparam logic [4:0] EV_EMPTY         = 5'd11;
	localparam logic [4:0] EV_UNCOMMIT      = 5'd12;
	localparam logic [4:0] EV_COMMIT_BYP    = 5'd13;
	localparam logic [4:0] EV_RECYCLE       = 5'd14;
	localparam logic [4:0] EV_ADDPIN        = 5'd15;
	localparam logic [4:0] EV_DROPPIN       = 5'd16;

	localparam int IDX_W = 10;
	localparam int MAX_DEPTH = 1 << IDX_W;

	typedef enum logic [1:0] {
		SQ_CLEAR,
		SQ_IDLE,
		SQ_LOOKUP
	} seq_t;

endpackage

/* design/heap_region_state_tracker.sv */
// Heap region state tracker: region table, event transition logic, output register.
// Depends on hrst_pkg.
// Result: request and table entry are registered, then the report goes to m_tdata.
// Requests are taken one at a time (table read, then write); a lookup waits while the last report is not taken.
// Reset: async, active low; then a clearing pass over min(REGION_COUNT, 1024) entries
// writes every table entry to empty uncommitted, free, no pins; s_tready stays low.
module heap_region_state_tracker
	import hrst_pkg::*;
#(
	parameter int REGION_COUNT = 1024,
	parameter int MAX_PINS     = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // action[4:0], region_index[14:5], owner_value[16:15]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // old_state[3:0], new_state[7:4], owner_now[9:8],
	                              // pins_now[17:10], illegal, commit_request,
	                              // uncommit_request, waste_release, age_reset,
	                              // used_release [23]
);

	localparam int DEPTH = (REGION_COUNT < MAX_DEPTH) ? REGION_COUNT : MAX_DEPTH;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PW    = $clog2(MAX_PINS + 1);
	localparam int WW    = PW + 6;

	logic [WW-1:0] mem [DEPTH];

	seq_t          seq_q, seq_d;
	logic [AW-1:0] clr_q;
	logic [WW-1:0] rd_q;
	logic [4:0]    act_q;
	logic [1:0]    ov_q;
	logic [AW-1:0] idx_q;
	logic          oor_q;
	logic          m_valid_q;
	logic [23:0]   m_data_q;

	logic [4:0]    in_act;
	logic [IDX_W-1:0] in_idx;
	logic [1:0]    in_ov;
	logic          accept, fin, clr_last;
	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [WW-1:0] mem_wd;

	logic [3:0]    st, nst;
	logic [1:0]    own, nown;
	logic [PW-1:0] pins, npins;
	logic          bad, com, unc, waste, age, used;
	logic [3:0]    r_nst;
	logic [1:0]    r_nown;
	logic [PW-1:0] r_npins;
	logic [15:0]   pins_w;
	logic [23:0]   res;

	assign in_act = s_tdata[4:0];
	assign in_idx = s_tdata[14:5];
	assign in_ov  = s_tdata[16:15];

	assign accept   = s_tvalid && s_tready;
	assign fin      = !m_valid_q || m_tready;
	assign clr_last = (clr_q == AW'(DEPTH - 1));

	assign st   = rd_q[3:0];
	assign own  = rd_q[5:4];
	assign pins = rd_q[WW-1:6];

	always_comb begin
		nst   = st;
		nown  = own;
		npins = pins;
		bad   = 1'b0;
		com   = 1'b0;
		unc   = 1'b0;
		waste = 1'b0;
		age   = 1'b0;
		used  = 1'b0;
		case (act_q)
			EV_REGALLOC: begin
				age = 1'b1;
				if (st == RS_EMPTY_UNC) begin
					com = 1'b1;
					nst = RS_REGULAR;
				end else if (st == RS_EMPTY_COM) begin
					nst = RS_REGULAR;
				end else if (st != RS_REGULAR && st != RS_PINNED) begin
					bad = 1'b1;
				end
			end
			EV_YOUNGIFREE: begin
				if (st inside {RS_EMPTY_UNC, RS_EMPTY_COM, RS_CSET, RS_HUM_START,
						RS_HUM_CONT}) begin
					nown = OWN_YOUNG;
				end else if (!(st inside {RS_PIN_CSET, RS_REGULAR, RS_PINNED})) begin
					bad = 1'b1;
				end
			end
			EV_REGBYPASS: begin
				age = 1'b1;
				if (st == RS_EMPTY_UNC) begin
					com = 1'b1;
					nst = RS_REGULAR;
				end else if (st == RS_EMPTY_COM || st == RS_CSET) begin
					nst = RS_REGULAR;
				end else if (st == RS_HUM_START || st == RS_HUM_CONT) begin
					waste = 1'b1;
					nst   = RS_REGULAR;
				end else if (st == RS_PIN_CSET) begin
					nst = RS_PINNED;
				end else if (st != RS_REGULAR && st != RS_PINNED) begin
					bad = 1'b1;
				end
			end
			EV_HUMSTART, EV_HUMCONT: begin
				age = 1'b1;
				if (st == RS_EMPTY_UNC || st == RS_EMPTY_COM) begin
					com = (st == RS_EMPTY_UNC);
					nst = (act_q == EV_HUMSTART) ? RS_HUM_START : RS_HUM_CONT;
				end else begin
					bad = 1'b1;
				end
			end
			EV_HUMSTART_BYP, EV_HUMCONT_BYP: begin
				age = 1'b1;
				if (ov_q > OWN_OLD) begin
					bad = 1'b1;
				end else if (st inside {RS_EMPTY_COM, RS_REGULAR, RS_HUM_START,
						RS_HUM_CONT}) begin
					nst  = (act_q == EV_HUMSTART_BYP) ? RS_HUM_START : RS_HUM_CONT;
					nown = ov_q;
				end else begin
					bad = 1'b1;
				end
			end
			EV_PIN: begin
				if (pins == '0) begin
					bad = 1'b1;
				end else if (st == RS_REGULAR) begin
					nst = RS_PINNED;
				end else if (st == RS_HUM_START) begin
					nst = RS_PIN_HUM;
				end else if (st == RS_CSET) begin
					nst = RS_PIN_CSET;
				end else if (!(st inside {RS_PIN_CSET, RS_PINNED, RS_PIN_HUM})) begin
					bad = 1'b1;
				end
			end
			EV_UNPIN: begin
				if (pins != '0) begin
					bad = 1'b1;
				end else if (st == RS_PINNED) begin
					nst = RS_REGULAR;
				end else if (st == RS_PIN_CSET) begin
					nst = RS_CSET;
				end else if (st == RS_PIN_HUM) begin
					nst = RS_HUM_START;
				end else if (st != RS_REGULAR && st != RS_HUM_START) begin
					bad = 1'b1;
				end
			end
			EV_CSET: begin
				if (st == RS_REGULAR) begin
					nst = RS_CSET;
				end else if (st != RS_CSET) begin
					bad = 1'b1;
				end
			end
			EV_TRASH: begin
				age = 1'b1;
				if (st == RS_HUM_START || st == RS_HUM_CONT) begin
					waste = 1'b1;
					nst   = RS_TRASH;
				end else if (st == RS_CSET || st == RS_REGULAR) begin
					nst = RS_TRASH;
				end else begin
					bad = 1'b1;
				end
			end
			EV_EMPTY: begin
				age = 1'b1;
				if (st == RS_TRASH) begin
					nst = RS_EMPTY_COM;
				end else begin
					bad = 1'b1;
				end
			end
			EV_UNCOMMIT: begin
				if (st == RS_EMPTY_COM) begin
					unc = 1'b1;
					nst = RS_EMPTY_UNC;
				end else begin
					bad = 1'b1;
				end
			end
			EV_COMMIT_BYP: begin
				if (st == RS_EMPTY_UNC) begin
					com = 1'b1;
					nst = RS_EMPTY_COM;
				end else begin
					bad = 1'b1;
				end
			end
			EV_RECYCLE: begin
				if (st == RS_TRASH) begin
					used = 1'b1;
					age  = 1'b1;
					nst  = RS_EMPTY_COM;
					nown = OWN_FREE;
				end
			end
			EV_ADDPIN: begin
				if (pins < PW'(MAX_PINS)) begin
					npins = pins + PW'(1);
				end
			end
			EV_DROPPIN: begin
				if (pins == '0) begin
					bad = 1'b1;
				end else begin
					npins = pins - PW'(1);
				end
			end
			default: begin
				bad = 1'b1;
			end
		endcase
	end

	// illegal events leave the entry as it was and raise no request
	always_comb begin
		r_nst   = bad ? st : nst;
		r_nown  = bad ? own : nown;
		r_npins = bad ? pins : npins;
		pins_w  = 16'(r_npins);
		if (oor_q) begin
			res = 24'(1) << 18;
		end else begin
			res = {used & !bad, age & !bad, waste & !bad, unc & !bad, com & !bad, bad,
				pins_w[7:0], r_nown, r_nst, st};
		end
	end

	always_comb begin
		seq_d = seq_q;
		case (seq_q)
			SQ_CLEAR: begin
				if (clr_last) begin
					seq_d = SQ_IDLE;
				end
			end
			SQ_IDLE: begin
				if (s_tvalid) begin
					seq_d = SQ_LOOKUP;
				end
			end
			SQ_LOOKUP: begin
				if (fin) begin
					seq_d = SQ_IDLE;
				end
			end
			default: begin
				seq_d = SQ_CLEAR;
			end
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		mem_we   = 1'b0;
		mem_wa   = idx_q;
		mem_wd   = {r_npins, r_nown, r_nst};
		case (seq_q)
			SQ_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
				mem_wd = '0;
			end
			SQ_IDLE: begin
				s_tready = 1'b1;
			end
			SQ_LOOKUP: begin
				mem_we = fin && !oor_q && !bad;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q     <= SQ_CLEAR;
			clr_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			seq_q <= seq_d;
			if (seq_q == SQ_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (seq_q == SQ_LOOKUP && fin) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= in_act;
			ov_q  <= in_ov;
			idx_q <= in_idx[AW-1:0];
			oor_q <= (32'(in_idx) >= 32'(REGION_COUNT));
			rd_q  <= mem[in_idx[AW-1:0]];
		end
		if (seq_q == SQ_LOOKUP && fin) begin
			m_data_q <= res;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	a_lookup_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_q == SQ_LOOKUP && fin) |=> m_tvalid)
		else $error("lookup finished without a result");

	a_illegal_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_q == SQ_LOOKUP && (bad || oor_q)) |-> !mem_we)
		else $error("table written on an illegal request");

	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_q == SQ_CLEAR) |-> (!m_tvalid && !s_tready))
		else $error("activity during clearing pass");

	a_accept_to_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (seq_q == SQ_LOOKUP))
		else $error("request taken without lookup");

endmodule

/* tb/tb_heap_region_state_tracker.sv */
// Testbench for heap_region_state_tracker: region events in, one transition report out per request.
// Holds its own copy of the region table and checks every report in order of acceptance.
// Depends on hrst_pkg and the heap_region_state_tracker RTL.
module tb_heap_region_state_tracker;
	timeunit 1ns;
	timeprecision 1ps;
	import hrst_pkg::*;

	localparam int PIN_LIMIT    = 255;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int RANDOM_ITEMS = 1564;
	localparam logic [4:0] EV_UNKNOWN_LO = 5'd17;
	localparam logic [4:0] EV_UNKNOWN_HI = 5'd31;

	typedef struct packed {
		logic [6:0] spare;
		logic [1:0] owner_value;
		logic [9:0] region_index;
		logic [4:0] action;
	} region_request_t;

	typedef struct packed {
		logic       used_release;
		logic       age_reset;
		logic       waste_release;
		logic       uncommit_request;
		logic       commit_request;
		logic       illegal;
		logic [7:0] pins_now;
		logic [1:0] owner_now;
		logic [3:0] new_state;
		logic [3:0] old_state;
	} region_report_t;

	class region_table_model;
		rstate_t        state_tab [MAX_DEPTH];
		logic [1:0]     owner_tab [MAX_DEPTH];
		int             pin_tab [MAX_DEPTH];
		region_report_t awaited_reports [$];
		int             mismatch_count;

		function new();
			foreach (state_tab[i]) begin
				state_tab[i] = RS_EMPTY_UNC;
				owner_tab[i] = OWN_FREE;
				pin_tab[i] = 0;
			end
			mismatch_count = 0;
		endfunction

		function region_report_t region_transition(region_request_t q);
			region_report_t r;
			rstate_t        st;
			rstate_t        nst;
			logic [1:0]     own;
			logic [1:0]     nown;
			int             pins;
			int             npins;
			bit             bad;
			st = state_tab[q.region_index];
			own = owner_tab[q.region_index];
			pins = pin_tab[q.region_index];
			nst = st;
			nown = own;
			npins = pins;
			r = '0;
			bad = 0;
			case (q.action)
			EV_REGALLOC: begin
				r.age_reset = 1;
				if (st == RS_EMPTY_UNC) begin
					r.commit_request = 1;
					nst = RS_REGULAR;
				end else if (st == RS_EMPTY_COM) begin
					nst = RS_REGULAR;
				end else if (st != RS_REGULAR && st != RS_PINNED) begin
					bad = 1;
				end
			end
			EV_YOUNGIFREE: begin
				if (st == RS_EMPTY_UNC || st == RS_EMPTY_COM || st == RS_CSET ||
				    st == RS_HUM_START || st == RS_HUM_CONT) begin
					nown = OWN_YOUNG;
				end else if (st != RS_PIN_CSET && st != RS_REGULAR && st != RS_PINNED) begin
					bad = 1;
				end
			end
			EV_REGBYPASS: begin
				r.age_reset = 1;
				if (st == RS_EMPTY_UNC) begin
					r.commit_request = 1;
					nst = RS_REGULAR;
				end else if (st == RS_EMPTY_COM || st == RS_CSET) begin
					nst = RS_REGULAR;
				end else if (st == RS_HUM_START || st == RS_HUM_CONT) begin
					r.waste_release = 1;
					nst = RS_REGULAR;
				end else if (st == RS_PIN_CSET) begin
					nst = RS_PINNED;
				end else if (st != RS_REGULAR && st != RS_PINNED) begin
					bad = 1;
				end
			end
			EV_HUMSTART, EV_HUMCONT: begin
				r.age_reset = 1;
				if (st == RS_EMPTY_UNC || st == RS_EMPTY_COM) begin
					r.commit_request = (st == RS_EMPTY_UNC);
					if (q.action == EV_HUMSTART) nst = RS_HUM_START;
					else nst = RS_HUM_CONT;
				end else begin
					bad = 1;
				end
			end
			EV_HUMSTART_BYP, EV_HUMCONT_BYP: begin
				r.age_reset = 1;
				if (q.owner_value > OWN_OLD) begin
					bad = 1;
				end else if (st == RS_EMPTY_COM || st == RS_REGULAR ||
				             st == RS_HUM_START || st == RS_HUM_CONT) begin
					if (q.action == EV_HUMSTART_BYP) nst = RS_HUM_START;
					else nst = RS_HUM_CONT;
					nown = q.owner_value;
				end else begin
					bad = 1;
				end
			end
			EV_PIN: begin
				if (pins == 0) bad = 1;
				else if (st == RS_REGULAR) nst = RS_PINNED;
				else if (st == RS_HUM_START) nst = RS_PIN_HUM;
				else if (st == RS_CSET) nst = RS_PIN_CSET;
				else if (st != RS_PIN_CSET && st != RS_PINNED && st != RS_PIN_HUM) bad = 1;
			end
			EV_UNPIN: begin
				if (pins != 0) bad = 1;
				else if (st == RS_PINNED) nst = RS_REGULAR;
				else if (st == RS_PIN_CSET) nst = RS_CSET;
				else if (st == RS_PIN_HUM) nst = RS_HUM_START;
				else if (st != RS_REGULAR && st != RS_HUM_START) bad = 1;
			end
			EV_CSET: begin
				if (st == RS_REGULAR) nst = RS_CSET;
				else if (st != RS_CSET) bad = 1;
			end
			EV_TRASH: begin
				r.age_reset = 1;
				if (st == RS_HUM_START || st == RS_HUM_CONT) begin
					r.waste_release = 1;
					nst = RS_TRASH;
				end else if (st == RS_CSET || st == RS_REGULAR) begin
					nst = RS_TRASH;
				end else begin
					bad = 1;
				end
			end
			EV_EMPTY: begin
				r.age_reset = 1;
				if (st == RS_TRASH) nst = RS_EMPTY_COM;
				else bad = 1;
			end
			EV_UNCOMMIT: begin
				if (st == RS_EMPTY_COM) begin
					r.uncommit_request = 1;
					nst = RS_EMPTY_UNC;
				end else begin
					bad = 1;
				end
			end
			EV_COMMIT_BYP: begin
				if (st == RS_EMPTY_UNC) begin
					r.commit_request = 1;
					nst = RS_EMPTY_COM;
				end else begin
					bad = 1;
				end
			end
			EV_RECYCLE: begin
				if (st == RS_TRASH) begin
					r.used_release = 1;
					r.age_reset = 1;
					nst = RS_EMPTY_COM;
					nown = OWN_FREE;
				end
			end
			EV_ADDPIN: begin
				if (pins < PIN_LIMIT) npins = pins + 1;
			end
			EV_DROPPIN: begin
				if (pins == 0) bad = 1;
				else npins = pins - 1;
			end
			default: bad = 1;
			endcase
			if (bad) begin
				r = '0;
				r.illegal = 1;
				nst = st;
				nown = own;
				npins = pins;
			end
			r.old_state = st;
			r.new_state = nst;
			r.owner_now = nown;
			r.pins_now = npins[7:0];
			return r;
		endfunction

		function void take_request(region_request_t q);
			region_report_t r;
			r = region_transition(q);
			if (!r.illegal) begin
				state_tab[q.region_index] = rstate_t'(r.new_state);
				owner_tab[q.region_index] = r.owner_now;
				pin_tab[q.region_index] = r.pins_now;
			end
			awaited_reports.push_back(r);
		endfunction

		function void compare_field(string field, int want, int got);
			if (want != got) begin
				mismatch_count++;
				$display("%0t: %s expected %0d actual %0d", $time, field, want, got);
			end
		endfunction

		function void match_report(region_report_t got);
			region_report_t want;
			if (awaited_reports.size() == 0) begin
				mismatch_count++;
				$display("%0t: report expected none actual %h", $time, got);
				return;
			end
			want = awaited_reports.pop_front();
			compare_field("old_state", want.old_state, got.old_state);
			compare_field("new_state", want.new_state, got.new_state);
			compare_field("owner_now", want.owner_now, got.owner_now);
			compare_field("pins_now", want.pins_now, got.pins_now);
			compare_field("illegal", want.illegal, got.illegal);
			compare_field("commit_request", want.commit_request, got.commit_request);
			compare_field("uncommit_request", want.uncommit_request, got.uncommit_request);
			compare_field("waste_release", want.waste_release, got.waste_release);
			compare_field("age_reset", want.age_reset, got.age_reset);
			compare_field("used_release", want.used_release, got.used_release);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;

	region_table_model tracker = new();
	bit quiet;
	int cycle_count = 0;
	int pool [8];

	heap_region_state_tracker uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) tracker.match_report(region_report_t'(m_tdata));
	end

	function automatic int idle_gap();
		int roll;
		if (quiet) return 0;
		roll = $urandom_range(0, 99);
		if (roll < 50) return 0;
		if (roll < 88) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	initial begin
		int gap;
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			gap = idle_gap();
			repeat (gap) begin
				@(negedge clk);
				m_tready <= 0;
			end
			repeat ($urandom_range(1, 12)) begin
				@(negedge clk);
				m_tready <= 1;
			end
		end
	end

	function automatic region_request_t make_request(logic [4:0] action, int region, int owner);
		region_request_t q;
		q = '0;
		q.action = action;
		q.region_index = region;
		q.owner_value = owner;
		return q;
	endfunction

	// mostly events that the region's current state allows, the rest noise
	function automatic region_request_t random_request();
		region_request_t q;
		region_report_t  r;
		int              tries;
		q = '0;
		if ($urandom_range(0, 4) != 0) q.region_index = pool[$urandom_range(0, 7)];
		else q.region_index = $urandom_range(0, MAX_DEPTH - 1);
		if ($urandom_range(0, 9) < 7) begin
			for (tries = 0; tries < 12; tries++) begin
				q.action = $urandom_range(EV_REGALLOC, EV_DROPPIN);
				q.owner_value = $urandom_range(OWN_FREE, OWN_OLD);
				r = tracker.region_transition(q);
				if (!r.illegal) break;
			end
		end else begin
			if ($urandom_range(0, 5) == 0) q.action = $urandom_range(EV_UNKNOWN_LO, EV_UNKNOWN_HI);
			else q.action = $urandom_range(EV_REGALLOC, EV_DROPPIN);
			q.owner_value = $urandom_range(0, 3);
		end
		return q;
	endfunction

	task automatic send_request(region_request_t q);
		int gap;
		gap = idle_gap();
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 0;
		end
		@(negedge clk);
		s_tvalid <= 1;
		s_tdata <= q;
		do @(posedge clk); while (!s_tready);
		tracker.take_request(q);
	endtask

	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 0;
		while (tracker.awaited_reports.size() != 0) @(posedge clk);
	endtask

	initial begin
		int phase;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		quiet = 0;
		pool[0] = 0;
		pool[1] = MAX_DEPTH - 1;
		foreach (pool[i]) begin
			if (i > 1) pool[i] = $urandom_range(1, MAX_DEPTH - 2);
		end
		repeat (6) @(negedge clk);
		arst_n <= 1;

		send_request(make_request(EV_COMMIT_BYP, 5, OWN_FREE));
		send_request(make_request(EV_UNCOMMIT, 5, OWN_FREE));
		send_request(make_request(EV_REGALLOC, 0, OWN_OLD));
		send_request(make_request(EV_YOUNGIFREE, 0, OWN_FREE));
		send_request(make_request(EV_ADDPIN, 0, OWN_FREE));
		send_request(make_request(EV_PIN, 0, OWN_FREE));
		send_request(make_request(EV_REGALLOC, 0, OWN_FREE));
		send_request(make_request(EV_DROPPIN, 0, OWN_FREE));
		send_request(make_request(EV_UNPIN, 0, OWN_FREE));
		send_request(make_request(EV_CSET, 0, OWN_FREE));
		send_request(make_request(EV_YOUNGIFREE, 0, OWN_FREE));
		send_request(make_request(EV_PIN, 0, OWN_FREE));
		send_request(make_request(EV_TRASH, 0, OWN_FREE));
		send_request(make_request(EV_YOUNGIFREE, 0, OWN_FREE));
		send_request(make_request(EV_RECYCLE, 0, OWN_FREE));
		send_request(make_request(EV_RECYCLE, 0, OWN_FREE));
		send_request(make_request(EV_HUMSTART, MAX_DEPTH - 1, OWN_FREE));
		send_request(make_request(EV_HUMCONT_BYP, MAX_DEPTH - 1, OWN_OLD));
		send_request(make_request(EV_HUMSTART_BYP, MAX_DEPTH - 1, 3));
		send_request(make_request(EV_REGBYPASS, MAX_DEPTH - 1, OWN_FREE));
		send_request(make_request(EV_HUMCONT, MAX_DEPTH - 2, OWN_FREE));
		send_request(make_request(EV_TRASH, MAX_DEPTH - 2, OWN_FREE));
		send_request(make_request(EV_EMPTY, MAX_DEPTH - 2, OWN_FREE));
		send_request(make_request(EV_DROPPIN, 7, OWN_FREE));
		send_request(make_request(EV_UNKNOWN_LO, 682, OWN_YOUNG));
		send_request(make_request(EV_UNKNOWN_HI, 341, 3));
		drain_results();

		for (phase = 0; phase < 4; phase++) begin
			quiet = (phase == 2);
			// walk one region's pin count past saturation
			if (phase == 1) repeat (PIN_LIMIT + 5) send_request(make_request(EV_ADDPIN, pool[2], 0));
			repeat (RANDOM_ITEMS / 4) send_request(random_request());
			drain_results();
		end

		repeat (10) @(posedge clk);
		if (tracker.mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
